@@ rtl/ppb_pkg.sv @@
package ppb_pkg;

  localparam int RotW  = 16;
  localparam int PtW   = 20;
  localparam int ProdW = RotW + PtW;
  localparam int CamW  = 38;
  localparam int FocW  = 16;
  localparam int MultW = FocW + 1 + CamW;
  localparam int NumW  = MultW + 2;
  localparam int DivW  = 60;
  localparam int CfgW  = 60;
  localparam int RowW  = 3 * RotW;
  localparam int TrW   = 3 * PtW;

  typedef enum logic [2:0] {
    REG_ROT_ROW0,
    REG_ROT_ROW1,
    REG_ROT_ROW2,
    REG_TRANSLATION,
    REG_FOCAL,
    REG_PRINCIPAL,
    REG_IMAGE_SIZE
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_PREP,
    BK_DIV,
    BK_ACC
  } back_state_e;

  typedef struct packed {
    logic [RowW-1:0] rot0;
    logic [RowW-1:0] rot1;
    logic [RowW-1:0] rot2;
    logic [TrW-1:0]  trans;
  } xform_cfg_t;

  typedef struct packed {
    logic [FocW-1:0]        fx;
    logic [FocW-1:0]        fy;
    logic signed [FocW-1:0] cx;
    logic signed [FocW-1:0] cy;
  } lens_cfg_t;

  typedef struct packed {
    logic signed [CamW-1:0] xc;
    logic signed [CamW-1:0] yc;
    logic signed [CamW-1:0] zc;
    logic                   last;
  } cam_item_t;

endpackage

@@ rtl/ppb_front.sv @@
module ppb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppb_pkg::xform_cfg_t           cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [ppb_pkg::PtW-1:0] point_x_i,
  input  logic signed [ppb_pkg::PtW-1:0] point_y_i,
  input  logic signed [ppb_pkg::PtW-1:0] point_z_i,
  input  logic                          last_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output ppb_pkg::cam_item_t            item_o
);
  import ppb_pkg::*;

  logic                    adv;
  logic [RowW-1:0]         rows [3];
  logic signed [PtW-1:0]   pts [3];
  logic signed [ProdW-1:0] prod_d [3][3];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [CamW-1:0]  tr_d [3];
  logic signed [CamW-1:0]  tr_q [3];
  logic signed [CamW-1:0]  cam_d [3];
  logic signed [CamW-1:0]  cam_q [3];
  logic                    v1_q, v2_q, last1_q, last2_q;

  assign adv     = !v2_q || item_ready_i;
  assign ready_o = adv;

  assign rows[0] = cfg_i.rot0;
  assign rows[1] = cfg_i.rot1;
  assign rows[2] = cfg_i.rot2;
  assign pts[0]  = point_x_i;
  assign pts[1]  = point_y_i;
  assign pts[2]  = point_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(rows[r][RotW*c +: RotW]) * pts[c];
      end
      // translation moved to 24 fractional bits
      tr_d[r]  = CamW'($signed(cfg_i.trans[PtW*r +: PtW])) <<< 14;
      cam_d[r] = CamW'(prod_q[r][0]) + CamW'(prod_q[r][1]) + CamW'(prod_q[r][2]) + tr_q[r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= prod_d;
      tr_q    <= tr_d;
      last1_q <= last_i;
      cam_q   <= cam_d;
      last2_q <= last1_q;
    end
  end

  assign item_valid_o = v2_q;
  assign item_o.xc    = cam_q[0];
  assign item_o.yc    = cam_q[1];
  assign item_o.zc    = cam_q[2];
  assign item_o.last  = last2_q;

endmodule

@@ rtl/ppb_fifo.sv @@
module ppb_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);
  import ppb_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic [Width-1:0] rdata_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= wdata_i;
    if (pop_i)  rdata_q   <= mem[rd_q];
  end

endmodule

@@ rtl/ppb_back.sv @@
module ppb_back #(
  parameter int PixelBits = 12,
  parameter int CountBits = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ppb_pkg::lens_cfg_t    lens_i,
  input  logic [PixelBits-1:0]  width_i,
  input  logic [PixelBits-1:0]  height_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  ppb_pkg::cam_item_t    item_i,
  output logic                  result_valid_o,
  input  logic                  result_ready_i,
  output logic                  box_valid_o,
  output logic [PixelBits-1:0]  box_left_o,
  output logic [PixelBits-1:0]  box_top_o,
  output logic [PixelBits-1:0]  box_right_o,
  output logic [PixelBits-1:0]  box_bottom_o,
  output logic [CountBits-1:0]  inside_count_o
);
  import ppb_pkg::*;

  localparam int StepW = $clog2(PixelBits + 1);

  back_state_e state_q, state_d;
  logic        acc_en, stall;

  logic signed [MultW-1:0] fu_q, cu_q, fv_q, cv_q;
  logic signed [CamW-1:0]  zc_q;
  logic                    zpos_q, last_q;
  logic signed [NumW-1:0]  numu_q, numv_q;
  logic [NumW-1:0]         magu, magv;
  logic [DivW-1:0]         den;
  logic [DivW-1:0]         remu_q, remv_q, dsh_q;
  logic                    negu_q, negv_q;
  logic [PixelBits:0]      quou_q, quov_q;
  logic [StepW-1:0]        step_q;
  logic                    bitu, bitv;

  logic                 oku, okv, hit;
  logic [PixelBits-1:0] lo_col_q, lo_row_q, hi_col_q, hi_row_q;
  logic [PixelBits-1:0] lo_col_d, lo_row_d, hi_col_d, hi_row_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 res_ok;
  logic                 out_v_q, out_ok_q;
  logic [PixelBits-1:0] out_l_q, out_t_q, out_r_q, out_b_q;
  logic [CountBits-1:0] out_c_q;

  assign stall = last_q && out_v_q && !result_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    acc_en  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_SUM;
      BK_SUM:  state_d = BK_PREP;
      BK_PREP: state_d = BK_DIV;
      BK_DIV: begin
        if (step_q == StepW'(PixelBits)) state_d = BK_ACC;
      end
      BK_ACC: begin
        if (!stall) begin
          acc_en  = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    magu = numu_q[NumW-1] ? NumW'(-numu_q) : NumW'(numu_q);
    magv = numv_q[NumW-1] ? NumW'(-numv_q) : NumW'(numv_q);
    den  = DivW'(zc_q[CamW-2:0]) << 4;
    bitu = (remu_q >= dsh_q);
    bitv = (remv_q >= dsh_q);
  end

  // u = (f*a + c*z) / (16*z), rounded: q = (2|n| + d) / 2d, one bit a cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_MUL: begin
        fu_q   <= $signed({1'b0, lens_i.fx}) * item_i.xc;
        cu_q   <= lens_i.cx * item_i.zc;
        fv_q   <= $signed({1'b0, lens_i.fy}) * item_i.yc;
        cv_q   <= lens_i.cy * item_i.zc;
        zc_q   <= item_i.zc;
        zpos_q <= (item_i.zc > 0);
        last_q <= item_i.last;
      end
      BK_SUM: begin
        numu_q <= NumW'(fu_q) + NumW'(cu_q);
        numv_q <= NumW'(fv_q) + NumW'(cv_q);
      end
      BK_PREP: begin
        negu_q <= numu_q[NumW-1];
        negv_q <= numv_q[NumW-1];
        remu_q <= DivW'({magu, 1'b0}) + den;
        remv_q <= DivW'({magv, 1'b0}) + den;
        dsh_q  <= den << (PixelBits + 1);
        step_q <= '0;
      end
      BK_DIV: begin
        if (bitu) remu_q <= remu_q - dsh_q;
        if (bitv) remv_q <= remv_q - dsh_q;
        quou_q <= {quou_q[PixelBits-1:0], bitu};
        quov_q <= {quov_q[PixelBits-1:0], bitv};
        dsh_q  <= dsh_q >> 1;
        step_q <= step_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    // top quotient bit set means the pixel is past any coordinate
    oku = zpos_q && !quou_q[PixelBits] && (!negu_q || quou_q == '0);
    okv = zpos_q && !quov_q[PixelBits] && (!negv_q || quov_q == '0);
    hit = oku && okv && (quou_q[PixelBits-1:0] < width_i) &&
          (quov_q[PixelBits-1:0] < height_i);
    lo_col_d = lo_col_q;
    lo_row_d = lo_row_q;
    hi_col_d = hi_col_q;
    hi_row_d = hi_row_q;
    cnt_d    = cnt_q;
    if (hit) begin
      if (quou_q[PixelBits-1:0] < lo_col_q) lo_col_d = quou_q[PixelBits-1:0];
      if (quov_q[PixelBits-1:0] < lo_row_q) lo_row_d = quov_q[PixelBits-1:0];
      if (quou_q[PixelBits-1:0] > hi_col_q) hi_col_d = quou_q[PixelBits-1:0];
      if (quov_q[PixelBits-1:0] > hi_row_q) hi_row_d = quov_q[PixelBits-1:0];
      if (cnt_q != '1) cnt_d = cnt_q + 1'b1;
    end
    res_ok = (cnt_d != '0) && (lens_i.fx != '0) && (lens_i.fy != '0) &&
             (width_i != '0) && (height_i != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_col_q <= '1;
      lo_row_q <= '1;
      hi_col_q <= '0;
      hi_row_q <= '0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      if (acc_en && last_q)  out_v_q <= 1'b1;
      else if (result_ready_i) out_v_q <= 1'b0;
      if (acc_en) begin
        if (last_q) begin
          lo_col_q <= '1;
          lo_row_q <= '1;
          hi_col_q <= '0;
          hi_row_q <= '0;
          cnt_q    <= '0;
        end else begin
          lo_col_q <= lo_col_d;
          lo_row_q <= lo_row_d;
          hi_col_q <= hi_col_d;
          hi_row_q <= hi_row_d;
          cnt_q    <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en && last_q) begin
      out_ok_q <= res_ok;
      out_l_q  <= res_ok ? lo_col_d : '0;
      out_t_q  <= res_ok ? lo_row_d : '0;
      out_r_q  <= res_ok ? hi_col_d : '0;
      out_b_q  <= res_ok ? hi_row_d : '0;
      out_c_q  <= res_ok ? cnt_d : '0;
    end
  end

  assign result_valid_o = out_v_q;
  assign box_valid_o    = out_ok_q;
  assign box_left_o     = out_l_q;
  assign box_top_o      = out_t_q;
  assign box_right_o    = out_r_q;
  assign box_bottom_o   = out_b_q;
  assign inside_count_o = out_c_q;

endmodule

@@ rtl/point_projection_bbox_unit.sv @@
// channel   direction  handshake                  payload
// point     in         point_valid_i/point_ready_o  point_x_i point_y_i point_z_i last_point_i
// result    out        result_valid_o/result_ready_i box_valid_o box_left_o box_top_o
//                                                  box_right_o box_bottom_o inside_count_o
// config    in         cfg_valid_i/cfg_ready_o    cfg_index_i cfg_data_i
//
// the transform front takes one point a cycle into a four-entry queue, unless the queue is full
// the projection back takes a new point only when idle and steps it through multiply, sum,
// prepare, a bit-serial divide (one quotient bit a cycle for u and v together) and accumulate
// reset restores the identity rotation, zero for the other registers, and an empty box
// a result waiting on result_ready_i stalls only the last point of the next set
module point_projection_bbox_unit #(
  parameter int PIXEL_BITS = 12,
  parameter int COUNT_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [2:0]                     cfg_index_i,
  input  logic [ppb_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                           point_valid_i,
  output logic                           point_ready_o,
  input  logic signed [ppb_pkg::PtW-1:0] point_x_i,
  input  logic signed [ppb_pkg::PtW-1:0] point_y_i,
  input  logic signed [ppb_pkg::PtW-1:0] point_z_i,
  input  logic                           last_point_i,
  output logic                           result_valid_o,
  input  logic                           result_ready_i,
  output logic                           box_valid_o,
  output logic [PIXEL_BITS-1:0]          box_left_o,
  output logic [PIXEL_BITS-1:0]          box_top_o,
  output logic [PIXEL_BITS-1:0]          box_right_o,
  output logic [PIXEL_BITS-1:0]          box_bottom_o,
  output logic [COUNT_BITS-1:0]          inside_count_o
);
  import ppb_pkg::*;

  xform_cfg_t              xf_q;
  lens_cfg_t               lens_q;
  logic [2*PIXEL_BITS-1:0] img_q;

  cam_item_t front_item, fifo_item;
  logic      front_valid, fifo_full, fifo_empty, fifo_pop, fifo_push;
  logic [$bits(cam_item_t)-1:0] fifo_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xf_q.rot0  <= RowW'(16384);
      xf_q.rot1  <= RowW'(1073741824);
      xf_q.rot2  <= RowW'(64'd70368744177664);
      xf_q.trans <= '0;
      lens_q     <= '0;
      img_q      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROT_ROW0:    xf_q.rot0  <= cfg_data_i[RowW-1:0];
        REG_ROT_ROW1:    xf_q.rot1  <= cfg_data_i[RowW-1:0];
        REG_ROT_ROW2:    xf_q.rot2  <= cfg_data_i[RowW-1:0];
        REG_TRANSLATION: xf_q.trans <= cfg_data_i[TrW-1:0];
        REG_FOCAL: begin
          lens_q.fx <= cfg_data_i[FocW-1:0];
          lens_q.fy <= cfg_data_i[2*FocW-1:FocW];
        end
        REG_PRINCIPAL: begin
          lens_q.cx <= cfg_data_i[FocW-1:0];
          lens_q.cy <= cfg_data_i[2*FocW-1:FocW];
        end
        REG_IMAGE_SIZE:  img_q <= cfg_data_i[2*PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  ppb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (xf_q),
    .valid_i      (point_valid_i),
    .ready_o      (point_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_i       (last_point_i),
    .item_valid_o (front_valid),
    .item_ready_i (!fifo_full),
    .item_o       (front_item)
  );

  assign fifo_push = front_valid && !fifo_full;

  ppb_fifo #(
    .Width($bits(cam_item_t))
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (front_item),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .rdata_o (fifo_rdata)
  );

  assign fifo_item = cam_item_t'(fifo_rdata);

  ppb_back #(
    .PixelBits(PIXEL_BITS),
    .CountBits(COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lens_i         (lens_q),
    .width_i        (img_q[PIXEL_BITS-1:0]),
    .height_i       (img_q[2*PIXEL_BITS-1:PIXEL_BITS]),
    .empty_i        (fifo_empty),
    .pop_o          (fifo_pop),
    .item_i         (fifo_item),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .box_valid_o    (box_valid_o),
    .box_left_o     (box_left_o),
    .box_top_o      (box_top_o),
    .box_right_o    (box_right_o),
    .box_bottom_o   (box_bottom_o),
    .inside_count_o (inside_count_o)
  );

endmodule
